@@ hw/rtl/fys_pkg.sv @@
// fys_pkg: shared types and fixed widths for the shuffle block
// used by fys_divider and fisher_yates_shuffle; depends on nothing
`default_nettype none

package fys_pkg;

  // fixed port widths
  localparam int DATA_W = 32;
  localparam int RAND_W = 31;
  // divider step counter, holds 0 .. RAND_W-1
  localparam int STEP_W = $clog2(RAND_W);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_EM_RD,
    ST_EM_CAP,
    ST_EM_HOLD
  } fys_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/fys_ram.sv @@
// fys_ram: generic simple dual-port RAM, one write and one registered read a cycle
// standalone, no package dependency
`default_nettype none

module fys_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/fys_divider.sv @@
// fys_divider: restoring divider giving the remainder, one quotient bit a cycle
// depends on fys_pkg for the dividend width and step counter width
`default_nettype none

module fys_divider #(
  parameter int DIV_W = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [fys_pkg::RAND_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]          divisor,
  output      logic                      done,
  output      logic [DIV_W-1:0]          remainder
);

  logic                       busy_r;
  logic                       done_r;
  logic [fys_pkg::STEP_W-1:0] step_r;
  logic [fys_pkg::RAND_W-1:0] dvd_r;
  logic [DIV_W-1:0]           dvs_r;
  logic [DIV_W-1:0]           rem_r;
  logic [DIV_W:0]             trial;
  logic [DIV_W-1:0]           rem_nxt;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[fys_pkg::RAND_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == fys_pkg::STEP_W'(fys_pkg::RAND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[fys_pkg::RAND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ hw/rtl/fisher_yates_shuffle.sv @@
// fisher_yates_shuffle: collects a list, shuffles it in place and streams it out
// depends on fys_pkg, fys_ram and fys_divider
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_element_value, in_random_word, in_is_last
//   out     | output    | out_valid / out_ready  | out_value, out_last
//
// non-closing items can be taken back to back; the closing item starts the shuffle,
// which for each position reads element i, runs the remainder divider, reads
// element j and writes both back through the single-read element RAM; then
// each element is read, captured and held until taken. in_ready is low from the
// closing item until the final element has been taken.
// synchronous active-low reset returns to loading with an empty list;
// RAM contents are not cleared and need not be.
`default_nettype none

module fisher_yates_shuffle #(
  parameter int LIST_DEPTH = 32,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [fys_pkg::DATA_W-1:0] in_element_value,
  input  wire logic [fys_pkg::RAND_W-1:0] in_random_word,
  input  wire logic                       in_is_last,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [fys_pkg::DATA_W-1:0] out_value,
  output      logic                       out_last
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  fys_pkg::fys_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] k_r;
  logic [ELEM_WIDTH-1:0] elem_i_r;
  logic [fys_pkg::DATA_W-1:0] out_value_r;
  logic out_last_r;

  logic in_acc, out_acc, room;
  logic pos_final, k_final;

  logic                  e_we;
  logic [IDX_W-1:0]      e_waddr, e_raddr;
  logic [ELEM_WIDTH-1:0] e_wdata, e_rdata;
  logic                  r_we;
  logic [IDX_W-1:0]      r_raddr;
  logic [fys_pkg::RAND_W-1:0] r_rdata;

  logic             div_start, div_done;
  logic [CNT_W-1:0] div_rem;
  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] j_sum;

  logic [ELEM_WIDTH+fys_pkg::DATA_W-1:0] in_ext;
  logic [ELEM_WIDTH+fys_pkg::DATA_W-1:0] out_ext;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign room    = count_r < CNT_W'(LIST_DEPTH);

  assign pos_final = (CNT_W'(pos_r) + 1'b1) == count_r;
  assign k_final   = (CNT_W'(k_r) + 1'b1) == count_r;
  assign span      = count_r - CNT_W'(pos_r);
  assign j_sum     = div_rem + CNT_W'(pos_r);

  // width adaption of the element in both directions
  assign in_ext  = {{ELEM_WIDTH{1'b0}}, in_element_value};
  assign out_ext = {{fys_pkg::DATA_W{1'b0}}, e_rdata};

  fys_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  fys_ram #(
    .WIDTH (fys_pkg::RAND_W),
    .DEPTH (LIST_DEPTH)
  ) u_rand_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_random_word),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  fys_divider #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (r_rdata),
    .divisor   (span),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fys_pkg::ST_LOAD:     if (in_acc && in_is_last) state_nxt = fys_pkg::ST_RD_I;
      fys_pkg::ST_RD_I:     state_nxt = fys_pkg::ST_DIV_GO;
      fys_pkg::ST_DIV_GO:   state_nxt = fys_pkg::ST_DIV_WAIT;
      fys_pkg::ST_DIV_WAIT: if (div_done) state_nxt = fys_pkg::ST_RD_J;
      fys_pkg::ST_RD_J:     state_nxt = fys_pkg::ST_WR_I;
      fys_pkg::ST_WR_I:     state_nxt = fys_pkg::ST_WR_J;
      fys_pkg::ST_WR_J: begin
        state_nxt = pos_final ? fys_pkg::ST_EM_RD : fys_pkg::ST_RD_I;
      end
      fys_pkg::ST_EM_RD:    state_nxt = fys_pkg::ST_EM_CAP;
      fys_pkg::ST_EM_CAP:   state_nxt = fys_pkg::ST_EM_HOLD;
      fys_pkg::ST_EM_HOLD: begin
        if (out_acc) begin
          state_nxt = out_last_r ? fys_pkg::ST_LOAD : fys_pkg::ST_EM_RD;
        end
      end
      default:              state_nxt = fys_pkg::ST_LOAD;
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    e_we      = 1'b0;
    e_waddr   = count_r[IDX_W-1:0];
    e_wdata   = in_ext[ELEM_WIDTH-1:0];
    e_raddr   = pos_r;
    r_we      = 1'b0;
    r_raddr   = pos_r;
    unique case (state_r)
      fys_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        e_we     = in_acc && room;
        r_we     = in_acc && room;
      end
      fys_pkg::ST_DIV_GO: div_start = 1'b1;
      fys_pkg::ST_RD_J:   e_raddr = j_r;
      fys_pkg::ST_WR_I: begin
        // entry j read in the previous cycle lands at position i
        e_we    = 1'b1;
        e_waddr = pos_r;
        e_wdata = e_rdata;
      end
      fys_pkg::ST_WR_J: begin
        e_we    = 1'b1;
        e_waddr = j_r;
        e_wdata = elem_i_r;
      end
      fys_pkg::ST_EM_RD:   e_raddr = k_r;
      fys_pkg::ST_EM_HOLD: out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fys_pkg::ST_LOAD;
      count_r <= '0;
      pos_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && room) begin
        count_r <= count_r + 1'b1;
      end
      if (state_r == fys_pkg::ST_WR_J) begin
        pos_r <= pos_final ? '0 : pos_r + 1'b1;
      end
      if (out_acc) begin
        if (out_last_r) begin
          k_r     <= '0;
          count_r <= '0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == fys_pkg::ST_DIV_GO) begin
      elem_i_r <= e_rdata;
    end
    if (div_done) begin
      j_r <= j_sum[IDX_W-1:0];
    end
    if (state_r == fys_pkg::ST_EM_CAP) begin
      out_value_r <= out_ext[fys_pkg::DATA_W-1:0];
      out_last_r  <= k_final;
    end
  end

  assign out_value = out_value_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> (in_ready && count_r == '0))
    else $error("list not closed after final element");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == fys_pkg::ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("list count beyond depth");

  a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fys_pkg::ST_RD_J) |-> (CNT_W'(j_r) < count_r && j_r >= pos_r))
    else $error("swap partner outside the unshuffled part");
`endif

endmodule

`default_nettype wire

@@ dv/fisher_yates_shuffle_tb.sv @@
// fisher_yates_shuffle_tb: self-checking bench for the list shuffle block
// drives lists over the in_ channel, predicts the shuffled order and checks out_
// depends on fys_pkg and fisher_yates_shuffle
module fisher_yates_shuffle_tb;

  localparam int LIST_DEPTH   = 32;
  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_PCT     = 37;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 100;
  localparam int NUM_ROWS     = 18;

  typedef struct packed {
    logic [fys_pkg::DATA_W-1:0] value;
    logic                       last;
  } shuffled_elem_t;

  typedef struct packed {
    logic [fys_pkg::DATA_W-1:0] value;
    logic [fys_pkg::RAND_W-1:0] rword;
    logic                       last;
    logic                       typed;
    logic [fys_pkg::DATA_W-1:0] want;
  } stim_row_t;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_ready;
  logic [fys_pkg::DATA_W-1:0] in_element_value = '0;
  logic [fys_pkg::RAND_W-1:0] in_random_word   = '0;
  logic                       in_is_last       = 1'b0;
  logic                       out_valid;
  logic                       out_ready        = 1'b0;
  logic [fys_pkg::DATA_W-1:0] out_value;
  logic                       out_last;

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned rx_count    = 0;
  bit          no_idle     = 1'b0;
  bit          hold_done   = 1'b0;

  // predictor state: the list being collected
  logic [fys_pkg::DATA_W-1:0] list_elems [LIST_DEPTH];
  logic [fys_pkg::RAND_W-1:0] list_rand  [LIST_DEPTH];
  int unsigned                list_len = 0;
  shuffled_elem_t             shuffled_due [$];
  shuffled_elem_t             head_elem;

  // single-element lists come straight back with the last flag set
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 31'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h8000_0001, 31'h4000_0000, 1'b1, 1'b1, 32'h8000_0001},
    '{32'hA5A5_A5A5, 31'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h5A5A_5A5A, 31'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h1234_5678, 31'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h9ABC_DEF0, 31'h7FFF_FFFE, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0001, 31'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 31'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0003, 31'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0004, 31'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{32'hFFFF_0000, 31'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hF0F0_F0F0, 31'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0F0F_0F0F, 31'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hC3C3_C3C3, 31'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{32'h5555_5555, 31'h2AAA_AAAA, 1'b1, 1'b1, 32'h5555_5555},
    '{32'hAAAA_AAAA, 31'h5555_5555, 1'b1, 1'b1, 32'hAAAA_AAAA}
  };

  fisher_yates_shuffle #(
    .LIST_DEPTH(LIST_DEPTH),
    .ELEM_WIDTH(fys_pkg::DATA_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element_value(in_element_value),
    .in_random_word  (in_random_word),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_last        (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // append one expected element at the tail of the pending results
  function automatic void queue_due(input shuffled_elem_t e);
    shuffled_due.insert(shuffled_due.size(), e);
  endfunction

  // store one element; a closing one shuffles the list and, with queue_order, queues it
  function automatic void load_and_shuffle(input logic [fys_pkg::DATA_W-1:0] v,
                                           input logic [fys_pkg::RAND_W-1:0] r,
                                           input logic l, input bit queue_order);
    int unsigned                span;
    int unsigned                j;
    logic [fys_pkg::DATA_W-1:0] swap_tmp;
    if (list_len < LIST_DEPTH) begin
      list_elems[list_len] = v;
      list_rand[list_len]  = r;
      list_len++;
    end
    if (l) begin
      for (int unsigned i = 0; i < list_len; i++) begin
        span          = list_len - i;
        j             = (list_rand[i] % span) + i;
        swap_tmp      = list_elems[i];
        list_elems[i] = list_elems[j];
        list_elems[j] = swap_tmp;
      end
      if (queue_order) begin
        for (int unsigned k = 0; k < list_len; k++)
          queue_due('{list_elems[k], k + 1 == list_len});
      end
      list_len = 0;
    end
  endfunction

  function automatic logic [fys_pkg::RAND_W-1:0] pick_rand_word();
    case ($urandom_range(3))
      0: pick_rand_word = fys_pkg::RAND_W'($urandom_range(40));
      1: pick_rand_word = $urandom_range(1) ? '1 : '0;
      default: pick_rand_word = fys_pkg::RAND_W'($urandom());
    endcase
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic offer_element(input logic [fys_pkg::DATA_W-1:0] v,
                               input logic [fys_pkg::RAND_W-1:0] r,
                               input logic l, input bit queue_order);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    in_random_word   <= r;
    in_is_last       <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_and_shuffle(v, r, l, queue_order);
  endtask

  // receiver: random back-pressure, plus one long hold-off that backs up the block
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!hold_done && rx_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rx_count++;
      if (shuffled_due.size() == 0) begin
        flag_mismatch("result with nothing pending, out_value", out_value, '0);
      end else begin
        head_elem = shuffled_due.pop_front();
        if (out_value !== head_elem.value)
          flag_mismatch("out_value", out_value, head_elem.value);
        if (out_last !== head_elem.last)
          flag_mismatch("out_last", {31'b0, out_last}, {31'b0, head_elem.last});
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned items_sent;
    int unsigned list_no;
    int unsigned len;
    int unsigned sel;
    bit          paused;
    items_sent = 0;
    list_no    = 0;
    paused     = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      offer_element(directed_rows[n].value, directed_rows[n].rword, directed_rows[n].last,
                    !directed_rows[n].typed);
      if (directed_rows[n].typed)
        queue_due('{directed_rows[n].want, 1'b1});
    end

    while (items_sent < RANDOM_ITEMS) begin
      // first an overflowing list, then an exactly full one, then mostly short lists
      sel = $urandom_range(99);
      if (list_no == 0 || sel < 4)
        len = LIST_DEPTH + $urandom_range(1, 8);
      else if (list_no == 1 || sel < 8)
        len = LIST_DEPTH;
      else if (sel < 20)
        len = 1;
      else
        len = $urandom_range(2, 10);
      for (int unsigned k = 0; k < len; k++)
        offer_element($urandom(), pick_rand_word(), k + 1 == len, 1'b1);
      items_sent += (len > LIST_DEPTH) ? LIST_DEPTH : len;
      list_no++;
      no_idle <= (items_sent >= 150 && items_sent < 260);
      // let the block empty out completely once
      if (!paused && items_sent >= 320) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (shuffled_due.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (shuffled_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fys_pkg.sv
hw/rtl/fys_ram.sv
hw/rtl/fys_divider.sv
hw/rtl/fisher_yates_shuffle.sv
dv/fisher_yates_shuffle_tb.sv
